@@ rtl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP responder and cache package
// Shared types, codes and sizing constants of the ARP responder and cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] OWN_IP_RESET = 32'hC0A8_0074;
  localparam logic [15:0] OP_REQUEST   = 16'd1;
  localparam logic [15:0] OP_REPLY     = 16'd2;
  localparam logic [15:0] HW_ETHERNET  = 16'd1;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  typedef enum logic [1:0] {
    MODE_RX     = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_SEND   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FOP_NONE    = 2'd0,
    FOP_REQUEST = 2'd1,
    FOP_REPLY   = 2'd2
  } frame_op_t;

  typedef enum logic [2:0] {
    OUT_NOT_ME   = 3'd0,
    OUT_REPLIED  = 3'd1,
    OUT_CACHED   = 3'd2,
    OUT_IGNORED  = 3'd3,
    OUT_LOOKUP   = 3'd4,
    OUT_REQ_SENT = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] op_code;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } item_t;

  typedef struct packed {
    logic        frame_valid;
    frame_op_t   frame_op;
    logic [15:0] frame_hw_type;
    logic [15:0] frame_proto_type;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    outcome_t    outcome;
  } result_t;

  typedef struct packed {
    logic take_in;
    logic scan_clear;
    logic scan_run;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  scan_done;
    logic  out_free;
  } status_t;

endpackage

@@ rtl/arpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ARP responder and cache controller
// Sequences item intake, the cache scan of a lookup and the result load.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  arpc_pkg::status_t sts,
  output arpc_pkg::cmd_t    cmd
);
  import arpc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.mode == MODE_LOOKUP) begin
          state_nxt = ST_SCAN;
        end else if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.take_in = in_tvalid;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_LOOKUP) begin
          cmd.scan_clear = 1'b1;
        end else begin
          cmd.load_out = sts.out_free;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/arpc_dp.sv @@
// ----------------------------------------------------------------------------
// ARP responder and cache datapath
// Configuration, item register, address cache memory with valid bits,
// lookup scan pipeline and result register.
// ----------------------------------------------------------------------------
module arpc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [47:0]       cfg_wdata,
  input  arpc_pkg::item_t   in_item,
  input  logic              out_tready,
  output logic              out_tvalid,
  output arpc_pkg::result_t out_res,
  input  arpc_pkg::cmd_t    cmd,
  output arpc_pkg::status_t sts
);
  import arpc_pkg::*;

  logic [31:0]      own_ip_r;
  logic [47:0]      own_mac_r;
  item_t            item_r;
  logic [79:0]      mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [IDX_W-1:0] slot_r;
  logic [CNT_W-1:0] scan_addr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [79:0]      rd_data_r;
  logic             rd_ok_r;
  logic             hit_r;
  logic [47:0]      lmac_r;
  logic             out_tvalid_r;
  result_t          out_res_r;
  result_t          res_nxt;
  logic             for_me;
  logic             do_store;
  logic             issue;
  logic             match;
  logic [31:0]      rd_ip;
  logic [47:0]      rd_mac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= OWN_IP_RESET;
      own_mac_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OWN_IP:  own_ip_r  <= cfg_wdata[31:0];
        CFG_OWN_MAC: own_mac_r <= cfg_wdata;
        default:     own_ip_r  <= own_ip_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_r <= in_item;
    end
  end

  assign for_me   = (item_r.target_ip == own_ip_r);
  assign do_store = cmd.load_out && (item_r.mode == MODE_RX) && for_me &&
                    (item_r.op_code == OP_REPLY);
  assign issue    = cmd.scan_run && (scan_addr_r != CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[slot_r] <= {item_r.sender_mac, item_r.sender_ip};
    end
    if (issue) begin
      rd_data_r <= mem[scan_addr_r[IDX_W-1:0]];
      rd_ok_r   <= vld_r[scan_addr_r[IDX_W-1:0]];
      rd_idx_r  <= scan_addr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      slot_r <= '0;
    end else if (do_store) begin
      vld_r[slot_r] <= 1'b1;
      if (slot_r == IDX_W'(TABLE_ENTRIES - 1)) begin
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  assign rd_ip  = rd_ok_r ? rd_data_r[31:0]  : 32'd0;
  assign rd_mac = rd_ok_r ? rd_data_r[79:32] : 48'd0;
  assign match  = rd_vld_r && (rd_ip == item_r.target_ip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      lmac_r      <= '0;
    end else if (cmd.scan_clear) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      lmac_r      <= '0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
      if (match && !hit_r) begin
        hit_r  <= 1'b1;
        lmac_r <= rd_mac;
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    unique case (item_r.mode)
      MODE_RX: begin
        if (!for_me) begin
          res_nxt.outcome = OUT_NOT_ME;
        end else if (item_r.op_code == OP_REQUEST) begin
          res_nxt.frame_valid      = 1'b1;
          res_nxt.frame_op         = FOP_REPLY;
          res_nxt.frame_hw_type    = item_r.hw_type;
          res_nxt.frame_proto_type = item_r.proto_type;
          res_nxt.frame_target_mac = item_r.sender_mac;
          res_nxt.frame_target_ip  = item_r.sender_ip;
          res_nxt.outcome          = OUT_REPLIED;
        end else if (item_r.op_code == OP_REPLY) begin
          res_nxt.outcome = OUT_CACHED;
        end else begin
          res_nxt.outcome = OUT_IGNORED;
        end
      end
      MODE_LOOKUP: begin
        res_nxt.lookup_hit = hit_r;
        res_nxt.lookup_mac = lmac_r;
        res_nxt.outcome    = OUT_LOOKUP;
      end
      MODE_SEND: begin
        res_nxt.frame_valid      = 1'b1;
        res_nxt.frame_op         = FOP_REQUEST;
        res_nxt.frame_hw_type    = HW_ETHERNET;
        res_nxt.frame_proto_type = PROTO_IPV4;
        res_nxt.frame_target_mac = MAC_BCAST;
        res_nxt.frame_target_ip  = item_r.target_ip;
        res_nxt.outcome          = OUT_REQ_SENT;
      end
      MODE_NONE: begin
        res_nxt.outcome = OUT_IGNORED;
      end
      default: begin
        res_nxt.outcome = OUT_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_res       = out_res_r;
  assign sts.mode      = item_r.mode;
  assign sts.out_free  = !out_tvalid_r || out_tready;
  assign sts.scan_done = match || (rd_vld_r && (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1)));

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over an unaccepted result");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= IDX_W'(TABLE_ENTRIES - 1))
    else $error("insert slot beyond table");

  a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_res_r.lookup_hit) |-> (out_res_r.outcome == OUT_LOOKUP))
    else $error("lookup hit flagged on a non-lookup result");

  a_no_scan_store: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !do_store)
    else $error("cache written during a scan");

endmodule

@@ rtl/arp_responder_and_cache.sv @@
// ----------------------------------------------------------------------------
// ARP responder and cache
// Answers ARP requests, learns replies into an address cache, resolves
// lookups against the cache and generates broadcast ARP requests.
// ----------------------------------------------------------------------------
// Items enter on the in_ stream; in_tuser selects received packet, cache
// lookup or send request. Every item yields exactly one result item on the
// out_ stream, whose out_tuser carries the outcome code.
// The block holds one item at a time. A packet or send request passes from
// the item register into the result register once that register is free,
// and only then is the next item taken. A lookup reads the cache memory one
// entry per cycle, stopping at the first match or at the last entry; each
// read is registered at the memory read port before it is compared.
// The result register lets the next item be accepted while a result still
// waits; if the receiver stalls longer, the following result holds in the
// block and in_tready stays low until out_tready frees the register.
// Reset empties the cache (all entries read as zero IP and zero MAC), sets the
// insert slot to zero and own_ip to 192.168.0.116. The user must write own_ip
// and own_mac through the cfg_ port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module arp_responder_and_cache (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [47:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op_code, hw_type, proto_type, sender_mac, sender_ip, target_ip
  input  logic [159:0] in_tdata,
  // mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // frame_valid, frame_op, frame_hw_type, frame_proto_type, frame_target_mac,
  // frame_target_ip, lookup_hit, lookup_mac, zero padding
  output logic [167:0] out_tdata,
  // outcome
  output logic [2:0]   out_tuser
);
  import arpc_pkg::*;

  item_t   in_item;
  result_t out_res;
  cmd_t    cmd;
  status_t sts;

  assign in_item.mode       = mode_t'(in_tuser);
  assign in_item.op_code    = in_tdata[15:0];
  assign in_item.hw_type    = in_tdata[31:16];
  assign in_item.proto_type = in_tdata[47:32];
  assign in_item.sender_mac = in_tdata[95:48];
  assign in_item.sender_ip  = in_tdata[127:96];
  assign in_item.target_ip  = in_tdata[159:128];

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign out_tdata = {4'd0,
                      out_res.lookup_mac,
                      out_res.lookup_hit,
                      out_res.frame_target_ip,
                      out_res.frame_target_mac,
                      out_res.frame_proto_type,
                      out_res.frame_hw_type,
                      out_res.frame_op,
                      out_res.frame_valid};
  assign out_tuser = out_res.outcome;

endmodule
